FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low asynchronous reset disable.
`define HPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define HPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/hpg_pkg.sv
// ----------------------------------------------------------------------------
// Heap permutation generator package
// Types and constants shared by the permutation generator modules.
// ----------------------------------------------------------------------------
package hpg_pkg;

    localparam int PERM_W      = 64;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = PERM_W / DIGIT_W;
    localparam int DIGIT_IDX_W = 4;
    localparam int CNT_W       = 5;
    localparam int LEN_W       = 5;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd4;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP,
        ST_EMIT
    } hpg_state_t;

    typedef logic [PERM_W-1:0]      perm_t;
    typedef logic [DIGIT_IDX_W-1:0] digit_idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

endpackage

FILE: rtl/hpg_swap_unit.sv
// ----------------------------------------------------------------------------
// Digit swap unit
// Exchanges two 4-bit digits of a packed permutation word.
// ----------------------------------------------------------------------------
module hpg_swap_unit
    import hpg_pkg::*;
(
    input  perm_t      perm_in,
    input  digit_idx_t pos_a,
    input  digit_idx_t pos_b,
    output perm_t      perm_out
);

    logic [DIGIT_W-1:0] digit_a;
    logic [DIGIT_W-1:0] digit_b;

    assign digit_a = perm_in[pos_a*DIGIT_W +: DIGIT_W];
    assign digit_b = perm_in[pos_b*DIGIT_W +: DIGIT_W];

    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (DIGIT_IDX_W'(k) == pos_a)
            begin
                perm_out[k*DIGIT_W +: DIGIT_W] = digit_b;
            end
            else if (DIGIT_IDX_W'(k) == pos_b)
            begin
                perm_out[k*DIGIT_W +: DIGIT_W] = digit_a;
            end
            else
            begin
                perm_out[k*DIGIT_W +: DIGIT_W] = perm_in[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

endmodule

FILE: rtl/heap_permutation_generator_unit.sv
// ----------------------------------------------------------------------------
// Heap permutation generator unit
// Sequencing: a start, or an advance once the sequence is finished or with a zero
// length, goes from idle straight to the emit step. Any other advance scans the
// levels in turn and swaps at the first ready one, or emits with done set after the last.
// The shared counter compare examines one level per cycle.
// The emit step waits for a free output; the next transaction is accepted in the cycle
// after the result is loaded. Reset gives length 4, a zero word, level counters at 1 and done set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heap_permutation_generator_unit
    import hpg_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata,       // [4:0] digit count

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [PERM_W-1:0] s_axis_tdata,    // [63:0] start_perm
    input  logic              s_axis_tuser,    // [0] command

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [PERM_W-1:0] m_axis_tdata,    // [63:0] perm_out
    output logic              m_axis_tuser     // [0] done_res
);

    localparam int IDX_W = $clog2(MAX_DIGITS);

    hpg_state_t       state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    perm_t            perm_reg, perm_next;
    cnt_t             cnt_reg  [MAX_DIGITS];
    cnt_t             cnt_next [MAX_DIGITS];
    logic             exh_reg, exh_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_reg, last_next;
    digit_idx_t       pos_a_reg, pos_a_next;
    digit_idx_t       pos_b_reg, pos_b_next;
    logic             m_valid_reg, m_valid_next;
    perm_t            out_perm_reg, out_perm_next;
    logic             out_done_reg, out_done_next;

    logic             in_acc;
    logic             out_free;
    logic             out_load;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] len_dec;
    cnt_t             cnt_cur;
    cnt_t             cnt_dec;
    logic             level_found;
    perm_t            swapped;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign len_eff  = (len_reg > LEN_W'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS) : len_reg;
    assign len_dec  = len_eff - LEN_W'(1);
    assign cnt_cur  = cnt_reg[idx_reg];
    assign cnt_dec  = cnt_cur - CNT_W'(1);

    // Level i = idx + 1 is ready to swap when its counter is below i.
    assign level_found = (cnt_cur <= CNT_W'(idx_reg));

    hpg_swap_unit u_swap
    (
        .perm_in  (perm_reg),
        .pos_a    (pos_a_reg),
        .pos_b    (pos_b_reg),
        .perm_out (swapped)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == CMD_START || exh_reg || len_eff == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (level_found)
                begin
                    state_next = ST_SWAP;
                end
                else if (idx_reg == last_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SWAP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        len_next      = cfg_we ? cfg_wdata : len_reg;
        perm_next     = perm_reg;
        cnt_next      = cnt_reg;
        exh_next      = exh_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        pos_a_next    = pos_a_reg;
        pos_b_next    = pos_b_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        out_perm_next = out_perm_reg;
        out_done_next = out_done_reg;

        if (in_acc)
        begin
            idx_next  = '0;
            last_next = len_dec[IDX_W-1:0];
            if (s_axis_tuser == CMD_START)
            begin
                perm_next = s_axis_tdata;
                exh_next  = 1'b0;
                for (int k = 0; k < MAX_DIGITS; k++)
                begin
                    cnt_next[k] = CNT_W'(1);
                end
            end
            else if (len_eff == '0)
            begin
                exh_next = 1'b1;
            end
        end

        if (state_reg == ST_SCAN)
        begin
            if (level_found)
            begin
                cnt_next[idx_reg] = cnt_cur + CNT_W'(1);
                pos_b_next        = DIGIT_IDX_W'(idx_reg);
                pos_a_next        = idx_reg[0] ? cnt_dec[DIGIT_IDX_W-1:0] : '0;
            end
            else
            begin
                cnt_next[idx_reg] = CNT_W'(1);
                if (idx_reg == last_reg)
                begin
                    exh_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end

        if (state_reg == ST_SWAP)
        begin
            perm_next = swapped;
        end

        if (out_load)
        begin
            m_valid_next  = 1'b1;
            out_perm_next = perm_reg;
            out_done_next = exh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= LEN_RESET;
            perm_reg    <= '0;
            exh_reg     <= 1'b1;
            idx_reg     <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_DIGITS; k++)
            begin
                cnt_reg[k] <= CNT_W'(1);
            end
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            perm_reg    <= perm_next;
            exh_reg     <= exh_next;
            idx_reg     <= idx_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_a_reg    <= pos_a_next;
        pos_b_reg    <= pos_b_next;
        out_perm_reg <= out_perm_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_perm_reg;
    assign m_axis_tuser  = out_done_reg;

    `HPG_ASSERT(a_scan_in_range, clk, rst_n,
        (state_reg == ST_SCAN) |-> (idx_reg <= last_reg),
        "Level scan ran past the permutation length")

    `HPG_ASSERT(a_counter_nonzero, clk, rst_n,
        (state_reg == ST_SCAN) |-> (cnt_cur != '0),
        "Level counter reached zero during a scan")

    `HPG_ASSERT(a_swap_order, clk, rst_n,
        (state_reg == ST_SWAP) |-> (pos_a_reg <= pos_b_reg),
        "Swap positions are out of order")

    `HPG_ASSERT(a_load_from_emit, clk, rst_n,
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT),
        "Result presented outside the emit step")

    `HPG_ASSERT(a_start_clears_done, clk, rst_n,
        (in_acc && s_axis_tuser == CMD_START) |=> !exh_reg,
        "Start transaction did not clear the done flag")

endmodule
